// ===== design/wsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfc_pkg
// Shared constants, register indexes and helper functions for the wall
// segment frustum clip block.
// ----------------------------------------------------------------------------
package wsfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 32;
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = $clog2(NUM_CFG);

  // divider: one quotient bit per stage, plus input and output stages
  localparam int DIV_QB    = 32;
  localparam int DIV_LAT   = DIV_QB + 2;
  localparam int REM_W     = 33 + DIV_QB;
  localparam int MUL_LAT   = 3;

  // stage boundaries, counted in registers from the input
  localparam int B1        = DIV_LAT;
  localparam int B2        = B1 + MUL_LAT;
  localparam int B3        = B2 + DIV_LAT;
  localparam int B4        = B3 + MUL_LAT;
  localparam int B5        = B4 + DIV_LAT;

  localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
  localparam logic        [16:0] U_ONE   = 17'd65536;
  localparam int                 U_SH_R  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int                 U_SH_L  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_AX  = 3'd0,
    REG_LEFT_AY  = 3'd1,
    REG_LEFT_BX  = 3'd2,
    REG_LEFT_BY  = 3'd3,
    REG_RIGHT_AX = 3'd4,
    REG_RIGHT_AY = 3'd5,
    REG_RIGHT_BX = 3'd6,
    REG_RIGHT_BY = 3'd7
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_B505, 32'h0000_B505,
    32'h0000_0000, 32'h0000_0000, 32'h0000_B505, 32'hFFFF_4AFB
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return 33'(a) - 33'(b);
  endfunction

  // line parameter to 16 fraction bits
  function automatic logic [16:0] u_to_q16(input logic signed [31:0] u);
    logic [31:0] v;
    v = (32'(u) >> U_SH_R) << U_SH_L;
    return v[16:0];
  endfunction

endpackage

// ===== design/wsfc_seg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfc_seg_if
// Input channel: one wall segment item per handshake.
// ----------------------------------------------------------------------------
interface wsfc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seg_left_x;
  logic signed [31:0] seg_left_y;
  logic signed [31:0] seg_right_x;
  logic signed [31:0] seg_right_y;

  modport source (output valid, seg_left_x, seg_left_y, seg_right_x, seg_right_y,
                  input ready);
  modport sink   (input valid, seg_left_x, seg_left_y, seg_right_x, seg_right_y,
                  output ready);
endinterface

// ===== design/wsfc_clip_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfc_clip_if
// Output channel: one clipped segment item per handshake.
// ----------------------------------------------------------------------------
interface wsfc_clip_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] clip_left_x;
  logic signed [31:0] clip_left_y;
  logic        [16:0] clip_left_u;
  logic               left_was_cut;
  logic signed [31:0] clip_right_x;
  logic signed [31:0] clip_right_y;
  logic        [16:0] clip_right_u;
  logic               right_was_cut;

  modport source (output valid, clip_left_x, clip_left_y, clip_left_u, left_was_cut,
                  clip_right_x, clip_right_y, clip_right_u, right_was_cut,
                  input ready);
  modport sink   (input valid, clip_left_x, clip_left_y, clip_left_u, left_was_cut,
                  clip_right_x, clip_right_y, clip_right_u, right_was_cut,
                  output ready);
endinterface

// ===== design/wsfc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfc_div
// Pipelined fixed-point divider: sat32((num << FRAC_BITS) / den), truncated
// toward zero. One quotient bit per stage.
// ----------------------------------------------------------------------------
module wsfc_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] num,
  input  logic signed [32:0] den,
  output logic signed [31:0] q
);
  import wsfc_pkg::*;

  logic [32:0]       nabs;
  logic [32:0]       dabs;
  logic [REM_W-1:0]  nsh;
  logic [REM_W-1:0]  rem [DIV_QB+1];
  logic [32:0]       dm  [DIV_QB+1];
  logic [DIV_QB-1:0] qb  [DIV_QB+1];
  logic              ng  [DIV_QB+1];
  logic              ov  [DIV_QB+1];
  logic [DIV_QB-1:0] qm;
  logic signed [31:0] res;

  assign nabs = num[32] ? 33'(-num) : 33'(num);
  assign dabs = den[32] ? 33'(-den) : 33'(den);
  assign nsh  = REM_W'(nabs) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nsh;
      dm[0]  <= dabs;
      qb[0]  <= '0;
      ng[0]  <= num[32] ^ den[32];
      // quotient of 2^32 or more saturates regardless of the low bits
      ov[0]  <= nsh >= {dabs, {DIV_QB{1'b0}}};
    end
  end

  for (genvar k = 0; k < DIV_QB; k++) begin : g_bit
    localparam int BI = DIV_QB - 1 - k;
    logic [REM_W-1:0] dsh;
    logic [REM_W:0]   diff;
    logic             ge;

    assign dsh  = REM_W'(dm[k]) << BI;
    assign diff = {1'b0, rem[k]} - {1'b0, dsh};
    assign ge   = ~diff[REM_W];

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]     <= ge ? diff[REM_W-1:0] : rem[k];
        qb[k+1]      <= qb[k] | (DIV_QB'(ge) << BI);
        dm[k+1]      <= dm[k];
        ng[k+1]      <= ng[k];
        ov[k+1]      <= ov[k];
      end
    end
  end

  assign qm = qb[DIV_QB];

  always_comb begin
    if (ng[DIV_QB]) begin
      if (ov[DIV_QB] || (qm[31] && (|qm[30:0]))) begin
        res = 32'sh8000_0000;
      end else begin
        res = 32'(-qm);
      end
    end else begin
      if (ov[DIV_QB] || qm[31]) begin
        res = 32'sh7FFF_FFFF;
      end else begin
        res = qm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= res;
    end
  end

endmodule

// ===== design/wsfc_muladd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfc_muladd
// Three-stage fixed-point multiply-add: r = sat32(c +/- sat32(floor(a*b >>
// FRAC_BITS))). sub selects subtraction.
// ----------------------------------------------------------------------------
module wsfc_muladd (
  input  logic               clk,
  input  logic               en,
  input  logic               sub,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] c,
  output logic signed [31:0] r
);
  import wsfc_pkg::*;

  logic signed [63:0] prod;
  logic signed [31:0] ps;
  logic signed [31:0] c1;
  logic signed [31:0] c2;
  logic               sub1;
  logic               sub2;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
      c1   <= c;
      sub1 <= sub;
      // arithmetic shift gives floor rounding
      ps   <= sat32(prod >>> FRAC_BITS);
      c2   <= c1;
      sub2 <= sub1;
      r    <= sat32(sub2 ? 64'(c2) - 64'(ps) : 64'(c2) + 64'(ps));
    end
  end

endmodule

// ===== design/wall_segment_frustum_clip_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_segment_frustum_clip_core
// Clips a wall segment against a left and a right view frustum line.
//
// Usage: segments enter on the seg channel (valid/ready), one item per
// cycle. The clipped ends leave on the clip channel in the same order, one
// result item per input item. Clip lines are set through cfg_we/cfg_idx/
// cfg_data while no item is in flight.
// The path from accept to result valid runs through three 34-stage dividers
// (segment and clip slopes, intersection x, line parameter u) and two
// 3-stage multiply-add units, plus the output register.
// Throughput: one item per cycle while the receiver takes results.
// Reset clears all valid bits and loads the default clip lines (+/-45 deg).
// When the receiver stalls, the whole pipeline holds and seg.ready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module wall_segment_frustum_clip_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wsfc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [wsfc_pkg::CFG_W-1:0]          cfg_data,
  wsfc_seg_if.sink                            seg,
  wsfc_clip_if.source                         clip
);
  import wsfc_pkg::*;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               segv;
  } shr_t;

  typedef struct packed {
    logic signed [31:0] m;
    logic signed [31:0] b;
  } mb_t;

  logic [CFG_W-1:0]   cfg [NUM_CFG];
  logic               en;
  logic [B5-1:0]      vld;
  logic               out_valid;
  shr_t               sh  [B5];
  logic signed [31:0] m1_q;
  logic signed [31:0] m1_d [MUL_LAT];
  logic signed [31:0] b1_q;
  mb_t                mb1 [DIV_LAT];

  logic signed [31:0] clp_ax [2];
  logic signed [31:0] clp_ay [2];
  logic signed [31:0] clp_bx [2];
  logic signed [31:0] clp_by [2];

  logic signed [31:0] out_x   [2];
  logic signed [31:0] out_y   [2];
  logic        [16:0] out_u   [2];
  logic               out_cut [2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cfg[cfg_idx] <= cfg_data;
    end
  end

  assign clp_ax[0] = cfg[REG_LEFT_AX];
  assign clp_ay[0] = cfg[REG_LEFT_AY];
  assign clp_bx[0] = cfg[REG_LEFT_BX];
  assign clp_by[0] = cfg[REG_LEFT_BY];
  assign clp_ax[1] = cfg[REG_RIGHT_AX];
  assign clp_ay[1] = cfg[REG_RIGHT_AY];
  assign clp_bx[1] = cfg[REG_RIGHT_BX];
  assign clp_by[1] = cfg[REG_RIGHT_BY];

  // global advance: hold everything while a result waits
  assign en        = ~out_valid | clip.ready;
  assign seg.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[B5-2:0], seg.valid};
      out_valid <= vld[B5-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh[0] <= '{lx: seg.seg_left_x, ly: seg.seg_left_y,
                 rx: seg.seg_right_x, ry: seg.seg_right_y,
                 segv: (seg.seg_right_x == seg.seg_left_x)};
      for (int k = 1; k < B5; k++) begin
        sh[k] <= sh[k-1];
      end
    end
  end

  // segment slope and intercept
  wsfc_div u_div_m1 (
    .clk (clk), .en (en),
    .num (diff33(seg.seg_right_y, seg.seg_left_y)),
    .den (diff33(seg.seg_right_x, seg.seg_left_x)),
    .q   (m1_q)
  );

  wsfc_muladd u_mul_b1 (
    .clk (clk), .en (en), .sub (1'b1),
    .a (m1_q), .b (sh[B1-1].lx), .c (sh[B1-1].ly),
    .r (b1_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m1_d[0] <= m1_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        m1_d[k] <= m1_d[k-1];
      end
      mb1[0] <= '{m: m1_d[MUL_LAT-1], b: b1_q};
      for (int k = 1; k < DIV_LAT; k++) begin
        mb1[k] <= mb1[k-1];
      end
    end
  end

  for (genvar s = 0; s < 2; s++) begin : g_side
    logic               clpv;
    logic signed [31:0] m2_q;
    logic signed [31:0] m2_d [MUL_LAT];
    logic signed [31:0] b2_q;
    mb_t                mb2 [DIV_LAT];
    logic signed [31:0] xq;
    logic signed [31:0] xsel;
    logic               hit;
    logic signed [31:0] x_d [MUL_LAT];
    logic               h_d [MUL_LAT];
    logic signed [31:0] yq;
    logic signed [31:0] xf [DIV_LAT];
    logic signed [31:0] yf [DIV_LAT];
    logic               hf [DIV_LAT];
    logic signed [32:0] u_num;
    logic signed [32:0] u_den;
    logic signed [31:0] uq;
    logic               ygood;
    logic               cut;
    shr_t               s3;
    shr_t               s4;
    shr_t               s5;

    assign clpv = (clp_bx[s] == clp_ax[s]);
    assign s3   = sh[B3-1];
    assign s4   = sh[B4-1];
    assign s5   = sh[B5-1];

    // clip line slope and intercept
    wsfc_div u_div_m2 (
      .clk (clk), .en (en),
      .num (diff33(clp_by[s], clp_ay[s])),
      .den (diff33(clp_bx[s], clp_ax[s])),
      .q   (m2_q)
    );

    wsfc_muladd u_mul_b2 (
      .clk (clk), .en (en), .sub (1'b1),
      .a (m2_q), .b (clp_ax[s]), .c (clp_ay[s]),
      .r (b2_q)
    );

    // intersection x of two sloped lines
    wsfc_div u_div_x (
      .clk (clk), .en (en),
      .num (diff33(b2_q, b1_q)),
      .den (diff33(m1_d[MUL_LAT-1], m2_d[MUL_LAT-1])),
      .q   (xq)
    );

    always_comb begin
      if (s3.segv) begin
        xsel = s3.lx;
        hit  = ~clpv & (s3.ry != s3.ly);
      end else begin
        xsel = clpv ? clp_ax[s] : xq;
        hit  = clpv | (mb1[DIV_LAT-1].m != mb2[DIV_LAT-1].m);
      end
    end

    // y on whichever line is sloped
    wsfc_muladd u_mul_y (
      .clk (clk), .en (en), .sub (1'b0),
      .a (s3.segv ? mb2[DIV_LAT-1].m : mb1[DIV_LAT-1].m),
      .b (xsel),
      .c (s3.segv ? mb2[DIV_LAT-1].b : mb1[DIV_LAT-1].b),
      .r (yq)
    );

    always_comb begin
      if (s4.segv) begin
        u_num = diff33(yq, s4.ly);
        u_den = diff33(s4.ry, s4.ly);
      end else begin
        u_num = diff33(x_d[MUL_LAT-1], s4.lx);
        u_den = diff33(s4.rx, s4.lx);
      end
    end

    wsfc_div u_div_u (
      .clk (clk), .en (en),
      .num (u_num), .den (u_den),
      .q   (uq)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        m2_d[0] <= m2_q;
        for (int k = 1; k < MUL_LAT; k++) begin
          m2_d[k] <= m2_d[k-1];
        end
        mb2[0] <= '{m: m2_d[MUL_LAT-1], b: b2_q};
        for (int k = 1; k < DIV_LAT; k++) begin
          mb2[k] <= mb2[k-1];
        end
        x_d[0] <= xsel;
        h_d[0] <= hit;
        for (int k = 1; k < MUL_LAT; k++) begin
          x_d[k] <= x_d[k-1];
          h_d[k] <= h_d[k-1];
        end
        xf[0] <= x_d[MUL_LAT-1];
        yf[0] <= yq;
        hf[0] <= h_d[MUL_LAT-1];
        for (int k = 1; k < DIV_LAT; k++) begin
          xf[k] <= xf[k-1];
          yf[k] <= yf[k-1];
          hf[k] <= hf[k-1];
        end
      end
    end

    // left end needs y >= 0, right end y <= 0
    assign ygood = (s == 0) ? ~yf[DIV_LAT-1][31]
                            : (yf[DIV_LAT-1][31] | (yf[DIV_LAT-1] == 32'sd0));
    assign cut   = hf[DIV_LAT-1] & ~uq[31] & (uq <= ONE_Q)
                 & ~xf[DIV_LAT-1][31] & ygood;

    always_ff @(posedge clk) begin
      if (en) begin
        out_cut[s] <= cut;
        if (cut) begin
          out_x[s] <= xf[DIV_LAT-1];
          out_y[s] <= yf[DIV_LAT-1];
          out_u[s] <= u_to_q16(uq);
        end else begin
          out_x[s] <= (s == 0) ? s5.lx : s5.rx;
          out_y[s] <= (s == 0) ? s5.ly : s5.ry;
          out_u[s] <= (s == 0) ? 17'd0 : U_ONE;
        end
      end
    end
  end

  assign clip.valid         = out_valid;
  assign clip.clip_left_x   = out_x[0];
  assign clip.clip_left_y   = out_y[0];
  assign clip.clip_left_u   = out_u[0];
  assign clip.left_was_cut  = out_cut[0];
  assign clip.clip_right_x  = out_x[1];
  assign clip.clip_right_y  = out_y[1];
  assign clip.clip_right_u  = out_u[1];
  assign clip.right_was_cut = out_cut[1];

  a_left_keep_u : assert property (@(posedge clk) disable iff (rst)
    clip.valid && !clip.left_was_cut |-> clip.clip_left_u == 17'd0)
    else $error("left end kept but u is not zero");

  a_right_keep_u : assert property (@(posedge clk) disable iff (rst)
    clip.valid && !clip.right_was_cut |-> clip.clip_right_u == U_ONE)
    else $error("right end kept but u is not one");

  a_cut_u_range : assert property (@(posedge clk) disable iff (rst)
    clip.valid && (clip.left_was_cut || clip.right_was_cut)
      |-> clip.clip_left_u <= U_ONE && clip.clip_right_u <= U_ONE)
    else $error("cut end with u above one");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) && !rst |-> !clip.valid)
    else $error("result valid right after reset");

endmodule

// ===== sim/tb_wall_segment_frustum_clip_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wall_segment_frustum_clip_core
// Self-checking bench for the wall segment frustum clip core.
// A clocked driver streams wall segments from a queue, a clocked monitor
// predicts the clipped ends of every accepted segment in fixed point and
// compares each result field by field. Clip lines change between phases,
// including vertical lines and register extremes; both sides idle at random outside the last phase.
// ----------------------------------------------------------------------------
module tb_wall_segment_frustum_clip_core;
  import wsfc_pkg::*;

  typedef struct packed {
    logic signed [31:0] lx, ly, rx, ry;
  } segment_t;

  typedef struct packed {
    logic signed [31:0] lx, ly;
    logic        [16:0] lu;
    logic               lcut;
    logic signed [31:0] rx, ry;
    logic        [16:0] ru;
    logic               rcut;
  } clipped_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int SETTLE = 130;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  wsfc_seg_if  seg ();
  wsfc_clip_if clip ();

  wall_segment_frustum_clip_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .seg(seg.sink), .clip(clip.source)
  );

  always #4 clk = ~clk;

  segment_t pending_segs[$];
  clipped_t expected_clips[$];
  logic signed [31:0] clip_line[NUM_CFG];
  int  n_fail = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_cut = 0;
  bit  no_idle = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint sat(input longint v);
    return (v > QMAX) ? QMAX : (v < QMIN) ? QMIN : v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    longint p, q;
    p = a * b;
    q = p / (64'sd1 <<< FRAC_BITS);
    if ((p % (64'sd1 <<< FRAC_BITS)) != 0 && p < 0) q = q - 1;
    return sat(q);
  endfunction

  function automatic longint fx_div(input longint num, input longint den);
    return sat((num * (64'sd1 <<< FRAC_BITS)) / den);
  endfunction

  // intersection of the segment line with one clip line
  function automatic bit line_meet(input longint lx, ly, rx, ry, ax, ay, bx, by,
                                   output longint x, y, u);
    longint m1, b1, m2, b2;
    x = 0; y = 0; u = 0;
    if (rx != lx) begin
      m1 = fx_div(ry - ly, rx - lx);
      b1 = sat(ly - fx_mul(m1, lx));
      if (bx != ax) begin
        m2 = fx_div(by - ay, bx - ax);
        b2 = sat(ay - fx_mul(m2, ax));
        if (m1 == m2) return 1'b0;
        x = fx_div(b2 - b1, m1 - m2);
      end else begin
        x = ax;
      end
      y = sat(fx_mul(m1, x) + b1);
      u = fx_div(x - lx, rx - lx);
      return 1'b1;
    end
    if (bx == ax || ry == ly) return 1'b0;
    m2 = fx_div(by - ay, bx - ax);
    b2 = sat(ay - fx_mul(m2, ax));
    x = lx;
    y = sat(fx_mul(m2, x) + b2);
    u = fx_div(y - ly, ry - ly);
    return 1'b1;
  endfunction

  function automatic logic [16:0] u_q16(input longint u);
    logic [63:0] v;
    v = u;
    if (FRAC_BITS >= 16) v = v >> (FRAC_BITS - 16);
    else v = v << (16 - FRAC_BITS);
    return v[16:0];
  endfunction

  function automatic clipped_t clip_segment(input segment_t s);
    clipped_t r;
    longint x, y, u;
    longint one;
    bit hit;
    one = 64'sd1 <<< FRAC_BITS;
    r = '0;
    hit = line_meet(s.lx, s.ly, s.rx, s.ry, clip_line[REG_LEFT_AX], clip_line[REG_LEFT_AY],
                    clip_line[REG_LEFT_BX], clip_line[REG_LEFT_BY], x, y, u);
    if (hit && u >= 0 && u <= one && x >= 0 && y >= 0) begin
      r.lx = 32'(x); r.ly = 32'(y); r.lu = u_q16(u); r.lcut = 1'b1;
    end else begin
      r.lx = s.lx; r.ly = s.ly; r.lu = 17'd0; r.lcut = 1'b0;
    end
    hit = line_meet(s.lx, s.ly, s.rx, s.ry, clip_line[REG_RIGHT_AX], clip_line[REG_RIGHT_AY],
                    clip_line[REG_RIGHT_BX], clip_line[REG_RIGHT_BY], x, y, u);
    if (hit && u >= 0 && u <= one && x >= 0 && y <= 0) begin
      r.rx = 32'(x); r.ry = 32'(y); r.ru = u_q16(u); r.rcut = 1'b1;
    end else begin
      r.rx = s.rx; r.ry = s.ry; r.ru = U_ONE; r.rcut = 1'b0;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ driver
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      seg.valid <= 1'b0;
      seg.seg_left_x <= '0; seg.seg_left_y <= '0;
      seg.seg_right_x <= '0; seg.seg_right_y <= '0;
    end else if (!seg.valid || seg.ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        seg.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        src_gap <= $urandom_range(0, 14);
        seg.valid <= 1'b0;
      end else if (pending_segs.size() > 0) begin
        segment_t s;
        s = pending_segs.pop_front();
        seg.valid <= 1'b1;
        seg.seg_left_x <= s.lx; seg.seg_left_y <= s.ly;
        seg.seg_right_x <= s.rx; seg.seg_right_y <= s.ry;
      end else begin
        seg.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------- receiver + check
  int sink_stall = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      clip.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      clip.ready <= 1'b0;
    end else if (!long_hold_done && n_in >= 300) begin
      // hold off long enough for the pipeline to fill and push back
      long_hold_done <= 1'b1;
      sink_stall <= 399;
      clip.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(0, 14);
      clip.ready <= 1'b0;
    end else begin
      clip.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && seg.valid && seg.ready) begin
      expected_clips.push_back(clip_segment({seg.seg_left_x, seg.seg_left_y,
                                             seg.seg_right_x, seg.seg_right_y}));
      n_in++;
    end
    if (!rst && clip.valid && clip.ready) begin
      n_out++;
      if (expected_clips.size() == 0) begin
        $error("result with no segment waiting");
        n_fail++;
      end else begin
        clipped_t e;
        e = expected_clips.pop_front();
        if (e.lcut || e.rcut) n_cut++;
        check_field("clip_left_x", e.lx, clip.clip_left_x);
        check_field("clip_left_y", e.ly, clip.clip_left_y);
        check_field("clip_left_u", e.lu, clip.clip_left_u);
        check_field("left_was_cut", e.lcut, clip.left_was_cut);
        check_field("clip_right_x", e.rx, clip.clip_right_x);
        check_field("clip_right_y", e.ry, clip.clip_right_y);
        check_field("clip_right_u", e.ru, clip.clip_right_u);
        check_field("right_was_cut", e.rcut, clip.right_was_cut);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] near_coord();
    return $signed($urandom_range(0, 32'd40 << 16)) - $signed(32'd20 << 16);
  endfunction

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      3: return $signed($urandom_range(0, 64)) - 32;
      default: return near_coord();
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    logic signed [31:0] d;
    s = {any_coord(), any_coord(), any_coord(), any_coord()};
    case ($urandom_range(0, 9))
      0: s.rx = s.lx;                          // vertical
      1: begin s.rx = s.lx; s.ry = s.ly; end   // single point
      2: begin                                 // parallel to a clip line
        d = $urandom_range(1, 8);
        if ($urandom_range(0, 1)) begin
          s.rx = s.lx + d * (clip_line[REG_LEFT_BX] - clip_line[REG_LEFT_AX]);
          s.ry = s.ly + d * (clip_line[REG_LEFT_BY] - clip_line[REG_LEFT_AY]);
        end else begin
          s.rx = s.lx + d * (clip_line[REG_RIGHT_BX] - clip_line[REG_RIGHT_AX]);
          s.ry = s.ly + d * (clip_line[REG_RIGHT_BY] - clip_line[REG_RIGHT_AY]);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic signed [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    clip_line[idx] = v;
  endtask

  task automatic set_lines(input logic signed [31:0] v[NUM_CFG]);
    for (int i = 0; i < NUM_CFG; i++) write_reg(cfg_reg_t'(i), v[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_segs.size() == 0 && !seg.valid && expected_clips.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] lines[NUM_CFG];
    for (int i = 0; i < NUM_CFG; i++) clip_line[i] = CFG_RESET[i];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset clip lines at +/-45 degrees
    pending_segs.push_back({-32'sd10 <<< 16, 32'sd5 <<< 16, 32'sd10 <<< 16, 32'sd5 <<< 16});
    pending_segs.push_back({-32'sd10 <<< 16, -32'sd5 <<< 16, 32'sd10 <<< 16, -32'sd5 <<< 16});
    pending_segs.push_back({-32'sd8 <<< 16, 32'sd8 <<< 16, 32'sd8 <<< 16, -32'sd8 <<< 16});
    pending_segs.push_back({32'sd0, 32'sd5 <<< 16, 32'sd2 <<< 16, 32'sd7 <<< 16});
    pending_segs.push_back({32'sd3 <<< 16, -32'sd9 <<< 16, 32'sd3 <<< 16, 32'sd9 <<< 16});
    pending_segs.push_back({32'sd3 <<< 16, 32'sd4 <<< 16, 32'sd3 <<< 16, 32'sd4 <<< 16});
    pending_segs.push_back({32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    pending_segs.push_back({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF});
    pending_segs.push_back({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
    pending_segs.push_back({32'sd0, 32'sd0, 32'sd0, 32'sd0});
    pending_segs.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001});
    pending_segs.push_back({-32'sd1 <<< 16, 32'sd1 <<< 16, 32'sd1 <<< 16, 32'sd1 <<< 16});
    pending_segs.push_back({32'sd1 <<< 16, 32'sd1 <<< 16, 32'sd5 <<< 16, 32'sd1 <<< 16});
    pending_segs.push_back({32'sd0, 32'sd0, 32'sd4 <<< 16, 32'sd0});
    for (int i = 0; i < 200; i++) pending_segs.push_back(rand_segment());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lines = '{32'sd0, 32'sd0, -32'sd1 <<< 16, 32'sd2 <<< 16,
                     32'sd0, 32'sd0, 32'sd3 <<< 16, -32'sd1 <<< 16};
        1: lines = '{32'sd2 <<< 16, 32'sd0, 32'sd2 <<< 16, 32'sd5 <<< 16,
                     32'sd1 <<< 16, 32'sd0, 32'sd1 <<< 16, -32'sd5 <<< 16};
        2: lines = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
        3: lines = '{32'sd0, 32'sd0, 32'sd1, 32'sh7FFF_FFFF,
                     32'sd0, 32'sd0, 32'sd1, 32'sh8000_0000};
        6: lines = '{32'sd0, 32'sd0, 32'sd1 <<< 16, 32'sd0,
                     32'sd0, 32'sd0, 32'sd1 <<< 16, 32'sd0};
        7: lines = '{CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3],
                     CFG_RESET[4], CFG_RESET[5], CFG_RESET[6], CFG_RESET[7]};
        default:
          for (int i = 0; i < NUM_CFG; i++) lines[i] = near_coord();
      endcase
      set_lines(lines);
      no_idle = (ph == 7);
      for (int i = 0; i < 210; i++) pending_segs.push_back(rand_segment());
      drain();
    end

    $display("Segments: %0d in, %0d results, %0d with a cut end, 9 clip line settings",
             n_in, n_out, n_cut);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== wall_segment_frustum_clip_core.f =====
design/wsfc_pkg.sv
design/wsfc_seg_if.sv
design/wsfc_clip_if.sv
design/wsfc_div.sv
design/wsfc_muladd.sv
design/wall_segment_frustum_clip_core.sv
sim/tb_wall_segment_frustum_clip_core.sv
